/* hw/rtl/lphs_pkg.sv */
// Shared types and codes for the linear probing hash set.
package lphs_pkg;

  localparam int KEY_W  = 31;
  localparam int SIZE_W = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
  } lphs_in_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] status;
  } lphs_out_t;

  // Classified request handed from the front end to the probe engine.
  typedef struct packed {
    logic [1:0]        opcode;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] home;
  } lphs_job_t;

endpackage

/* hw/rtl/lphs_front.sv */
// Front end: accepts requests and works out the home slot by serial remainder.
module lphs_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lphs_pkg::lphs_in_t        in_data,
  input  logic [lphs_pkg::SIZE_W-1:0] size_n,
  output logic                      push_valid,
  input  logic                      push_ready,
  output lphs_pkg::lphs_job_t       push_job
);
  import lphs_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t           state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [4:0]        bit_r, bit_nxt;
  logic [SIZE_W:0]   shifted;

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_job   = '{opcode: op_r, key: key_r, home: rem_r};

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    shifted   = {rem_r, key_r[bit_r]};
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          key_nxt   = in_data.key;
          rem_nxt   = '0;
          bit_nxt   = 5'(KEY_W - 1);
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        // one quotient bit per cycle, remainder stays below the size
        if (shifted >= {1'b0, size_n}) begin
          rem_nxt = SIZE_W'(shifted - {1'b0, size_n});
        end else begin
          rem_nxt = shifted[SIZE_W-1:0];
        end
        if (bit_r == 5'd0) begin
          state_nxt = F_PUSH;
        end else begin
          bit_nxt = bit_r - 5'd1;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r  <= op_nxt;
    key_r <= key_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
  end

endmodule

/* hw/rtl/lphs_queue.sv */
// Two-entry job queue between the front end and the probe engine.
module lphs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  lphs_pkg::lphs_job_t push_job,
  output logic                pop_valid,
  input  logic                pop_ready,
  output lphs_pkg::lphs_job_t pop_job
);
  import lphs_pkg::*;

  lphs_job_t  buf_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = buf_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) buf_r[wr_r] <= push_job;
  end

endmodule

/* hw/rtl/lphs_back.sv */
// Probe engine: slot memory, linear probe sequencer and result register.
module lphs_back #(
  parameter int SLOTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lphs_pkg::SIZE_W-1:0] size_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  lphs_pkg::lphs_job_t         pop_job,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lphs_pkg::lphs_out_t         out_data
);
  import lphs_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = KEY_W + 2;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_PROBE, B_HOLD} bstate_t;

  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rd_q;
  logic [IW-1:0] raddr, waddr;
  logic [EW-1:0] wdata;
  logic          we;

  bstate_t           state_r, state_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [SIZE_W-1:0] cnt_r, cnt_nxt;
  logic              fvld_r, fvld_nxt;
  logic [IW-1:0]     free_r, free_nxt;
  lphs_out_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  lphs_out_t         out_data_r, out_data_nxt;

  logic [SIZE_W-1:0] n_m1;
  logic [IW-1:0]     last_idx, next_idx, ins_idx;
  logic [1:0]        mark;
  logic              hit, stop, ins_ok;

  assign n_m1      = size_n - SIZE_W'(1);
  assign last_idx  = IW'(n_m1);
  assign next_idx  = (cur_r == last_idx) ? '0 : cur_r + IW'(1);
  assign mark      = rd_q[EW-1 -: 2];
  assign hit       = (mark == MARK_USED) && (rd_q[KEY_W-1:0] == key_r);
  assign stop      = (mark == MARK_EMPTY) || hit || (cnt_r == n_m1);
  assign pop_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    fvld_nxt      = fvld_r;
    free_nxt      = free_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    raddr         = cur_r;
    we            = 1'b0;
    waddr         = cur_r;
    wdata         = {MARK_USED, key_r};
    ins_ok        = fvld_r || (mark != MARK_USED);
    ins_idx       = fvld_r ? free_r : cur_r;
    unique case (state_r)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = {MARK_EMPTY, key_r};
        if (clr_r == IW'(SLOTS - 1)) begin
          state_nxt = B_IDLE;
        end else begin
          clr_nxt = clr_r + IW'(1);
        end
      end
      B_IDLE: begin
        raddr = IW'(pop_job.home);
        if (pop_valid) begin
          op_nxt   = pop_job.opcode;
          key_nxt  = pop_job.key;
          cur_nxt  = IW'(pop_job.home);
          cnt_nxt  = '0;
          fvld_nxt = 1'b0;
          if (pop_job.opcode == OP_INSERT || pop_job.opcode == OP_FIND ||
              pop_job.opcode == OP_REMOVE) begin
            state_nxt = B_PROBE;
          end else begin
            res_nxt   = '{ok: 1'b0, status: ST_NOT_FOUND};
            state_nxt = B_HOLD;
          end
        end
      end
      B_PROBE: begin
        raddr = next_idx;
        if (stop) begin
          state_nxt = B_HOLD;
          case (op_r)
            OP_INSERT: begin
              if (hit) begin
                res_nxt = '{ok: 1'b0, status: ST_PRESENT};
              end else if (ins_ok) begin
                we      = 1'b1;
                waddr   = ins_idx;
                res_nxt = '{ok: 1'b1, status: ST_DONE};
              end else begin
                res_nxt = '{ok: 1'b0, status: ST_FULL};
              end
            end
            OP_FIND: begin
              res_nxt = hit ? '{ok: 1'b1, status: ST_DONE}
                            : '{ok: 1'b0, status: ST_NOT_FOUND};
            end
            default: begin
              if (hit) begin
                we      = 1'b1;
                wdata   = {MARK_DELETED, key_r};
                res_nxt = '{ok: 1'b1, status: ST_DONE};
              end else begin
                res_nxt = '{ok: 1'b0, status: ST_NOT_FOUND};
              end
            end
          endcase
        end else begin
          if (!fvld_r && mark != MARK_USED) begin
            fvld_nxt = 1'b1;
            free_nxt = cur_r;
          end
          cur_nxt = next_idx;
          cnt_nxt = cnt_r + SIZE_W'(1);
        end
      end
      B_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    cur_r      <= cur_nxt;
    cnt_r      <= cnt_nxt;
    fvld_r     <= fvld_nxt;
    free_r     <= free_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_PROBE |-> cnt_r < size_n)
    else $error("probe count ran past table size");
  a_rose_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == B_HOLD))
    else $error("result shown without a finished probe");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CLEAR |-> !pop_ready)
    else $error("job taken during clearing pass");

endmodule

/* hw/rtl/linear_probing_hash_set.sv */
// Top level of the linear probing hash set.
// Keys are 31-bit values kept in an open-addressed table of SLOTS entries, of
// which cfg table_size are in use (0 acts as 1, above SLOTS acts as SLOTS).
// Each item gives one result. The front end takes an item, then works out the
// home slot by a bit-serial remainder; a two-entry queue hands the job to
// the probe engine, which reads one slot per cycle from its memory and probes
// at most the size in use. Front and back overlap, so the front end can take
// a new item while the engine still probes an earlier one. After reset the
// engine sweeps all SLOTS entries to mark them empty; items are queued
// meanwhile but not processed. Write table_size only while idle.
module linear_probing_hash_set #(
  parameter int SLOTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lphs_pkg::lphs_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lphs_pkg::lphs_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [lphs_pkg::SIZE_W-1:0] cfg_wdata
);
  import lphs_pkg::*;

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] size_n;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  lphs_job_t         push_job, pop_job;

  // Hold the size register; reset value is 64, the full table at the default SLOTS.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(64);
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // Clamp the size in use to 1..SLOTS.
  always_comb begin
    size_n = size_r;
    if (size_r == '0) begin
      size_n = SIZE_W'(1);
    end else if (32'(size_r) > SLOTS) begin
      size_n = SIZE_W'(SLOTS);
    end
  end

  lphs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .size_n     (size_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  lphs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  lphs_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .size_n    (size_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
